### design/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned CELLS  = SLOTS - 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     valid;
  } cell_t;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic empty_nxt;
    logic full_nxt;
  } chain_stat_t;

endpackage

### design/cdq_req_if.sv
`timescale 1ns / 1ps

interface cdq_req_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

### design/cdq_rsp_if.sv
`timescale 1ns / 1ps

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic                     now_empty;
  logic                     now_full;

  modport source (output valid, output data, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input data, input status, input now_empty,
                  input now_full, output ready);
endinterface

### design/cdq_cell.sv
`timescale 1ns / 1ps

module cdq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::ctrl_t                    ctrl_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value_i,
  input  cdq_pkg::cell_t                    left_i,
  input  cdq_pkg::cell_t                    right_i,
  output cdq_pkg::cell_t                    cell_o,
  output logic                              valid_nxt_o,
  output logic signed [cdq_pkg::DATA_W-1:0] rear_val_o
);
  import cdq_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     is_tail_slot;
  logic                     is_last;

  assign is_tail_slot = !valid_q && left_i.valid;
  assign is_last      = valid_q && !right_i.valid;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.push_front) begin
      val_d   = left_i.val;
      valid_d = left_i.valid;
    end else if (ctrl_i.push_rear) begin
      if (is_tail_slot) begin
        val_d   = push_value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_front) begin
      val_d   = right_i.val;
      valid_d = right_i.valid;
    end else if (ctrl_i.pop_rear) begin
      if (is_last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign cell_o      = '{val: val_q, valid: valid_q};
  assign valid_nxt_o = valid_d;
  assign rear_val_o  = is_last ? val_q : '0;
endmodule

### design/cdq_chain.sv
`timescale 1ns / 1ps

module cdq_chain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::ctrl_t                    ctrl_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value_i,
  output logic signed [cdq_pkg::DATA_W-1:0] front_val_o,
  output logic signed [cdq_pkg::DATA_W-1:0] rear_val_o,
  output cdq_pkg::chain_stat_t              stat_o,
  output logic [cdq_pkg::CELLS-1:0]         valid_vec_o
);
  import cdq_pkg::*;

  cell_t                    cells   [CELLS];
  cell_t                    lefts   [CELLS];
  cell_t                    rights  [CELLS];
  logic signed [DATA_W-1:0] rear_hit[CELLS];
  logic [CELLS-1:0]         valid_nxt;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '{val: push_value_i, valid: 1'b1};
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == CELLS - 1) begin : g_tail
      assign rights[i] = '{val: '0, valid: 1'b0};
    end else begin : g_body
      assign rights[i] = cells[i+1];
    end

    cdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .push_value_i(push_value_i),
      .left_i      (lefts[i]),
      .right_i     (rights[i]),
      .cell_o      (cells[i]),
      .valid_nxt_o (valid_nxt[i]),
      .rear_val_o  (rear_hit[i])
    );

    assign valid_vec_o[i] = cells[i].valid;
  end

  always_comb begin
    rear_val_o = '0;
    for (int unsigned i = 0; i < CELLS; i++) begin
      rear_val_o = rear_val_o | rear_hit[i];
    end
  end

  assign front_val_o      = cells[0].val;
  assign stat_o.empty     = !cells[0].valid;
  assign stat_o.full      = cells[CELLS-1].valid;
  assign stat_o.empty_nxt = !valid_nxt[0];
  assign stat_o.full_nxt  = valid_nxt[CELLS-1];
endmodule

### design/circular_deque_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// req_i    in   valid / ready  operation[2:0], value[31:0] signed
// rsp_o    out  valid / ready  data[31:0] signed, status[1:0], now_empty, now_full
//
// One request per cycle while responses drain; the response is registered in the
// cycle after acceptance. A front push or pop moves all cells in one step.
// Reset empties the deque and drops any pending response.
// A new request is taken while the response register is empty or being drained;
// a stalled response holds the request side.

module circular_deque_top (
  input logic  clk_i,
  input logic  rst_ni,
  cdq_req_if.sink   req_i,
  cdq_rsp_if.source rsp_o
);
  import cdq_pkg::*;

  logic                     accept;
  op_e                      op;
  ctrl_t                    ctrl;
  logic signed [DATA_W-1:0] front_val, rear_val;
  chain_stat_t              stat;
  logic [CELLS-1:0]         valid_vec;

  logic                     rsp_valid_q;
  logic signed [DATA_W-1:0] data_q, data_d;
  status_e                  status_q, status_d;
  logic                     empty_q, empty_d;
  logic                     full_q, full_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.operation);

  always_comb begin
    ctrl     = '0;
    data_d   = '0;
    status_d = ST_OK;
    empty_d  = stat.empty;
    full_d   = stat.full;
    case (op)
      OP_PUSH_REAR: begin
        if (stat.full) status_d = ST_FULL;
        else ctrl.push_rear = accept;
      end
      OP_PUSH_FRONT: begin
        if (stat.full) status_d = ST_FULL;
        else ctrl.push_front = accept;
      end
      OP_POP_FRONT: begin
        if (stat.empty) status_d = ST_EMPTY;
        else begin
          ctrl.pop_front = accept;
          data_d         = front_val;
        end
      end
      OP_POP_REAR: begin
        if (stat.empty) status_d = ST_EMPTY;
        else begin
          ctrl.pop_rear = accept;
          data_d        = rear_val;
        end
      end
      OP_PEEK_FRONT: begin
        if (stat.empty) status_d = ST_EMPTY;
        else data_d = front_val;
      end
      OP_PEEK_REAR: begin
        if (stat.empty) status_d = ST_EMPTY;
        else data_d = rear_val;
      end
      default: ;
    endcase
    if (ctrl != '0) begin
      empty_d = stat.empty_nxt;
      full_d  = stat.full_nxt;
    end
  end

  cdq_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .push_value_i(req_i.value),
    .front_val_o (front_val),
    .rear_val_o  (rear_val),
    .stat_o      (stat),
    .valid_vec_o (valid_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q   <= data_d;
      status_q <= status_d;
      empty_q  <= empty_d;
      full_q   <= full_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.data      = data_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.now_empty = empty_q;
  assign rsp_o.now_full  = full_q;

  a_fill_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells not contiguous from the front");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stat.full && (op == OP_PUSH_REAR || op == OP_PUSH_FRONT)
    |=> rsp_o.valid && rsp_o.status == ST_FULL && $stable(valid_vec))
    else $error("push into full deque not refused");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !stat.empty && (op == OP_POP_FRONT || op == OP_POP_REAR)
    |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("pop did not remove exactly one element");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.now_empty == !valid_vec[0] && rsp_o.now_full == valid_vec[CELLS-1])
    else $error("response flags disagree with cell occupancy");
endmodule
